// ===== hdl/tmsw_pkg.sv =====
package tmsw_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 18;
    localparam int MEAN_W      = 16;
    localparam int MEAN_FRAC   = 4;
    localparam int SAMPLE_MAX  = 4095;
    localparam int SUM_MAX     = 262143;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - SUM_W - MEAN_W - 2 * SAMPLE_W;

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [SAMPLE_W-1:0]  window_high;
        logic [SAMPLE_W-1:0]  window_low;
        logic [MEAN_W-1:0]    mean_q4;
        logic [SUM_W-1:0]     trimmed_sum;
    } out_item_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_TRIM  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_EST   = 7'b0100000,
        S_FIX   = 7'b1000000
    } state_t;

endpackage

// ===== hdl/tmsw_ram.sv =====
module tmsw_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/trimmed_mean_sample_window_core.sv =====
// A result is registered after the SCAN, DRAIN, TRIM, MUL, EST and FIX states. A new
// sample is taken only in IDLE, once the previous result is in the output register;
// the scan reads every ring entry once through the single read port of the sample RAM.
// Reset: rst_n clears control state, the write slot and the per-entry valid bits,
// so the ring reads as all zero; no clearing pass is needed.
module trimmed_mean_sample_window_core #(
    parameter int WINDOW = 40
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tmsw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [11:0] sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [17:0] trimmed_sum, [33:18] mean_q4, [45:34] window_low, [57:46] window_high
    output logic [tmsw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import tmsw_pkg::*;

    localparam int AW      = $clog2(WINDOW);
    localparam int TOT_W   = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int NW      = TOT_W + MEAN_FRAC;
    localparam int DIVISOR = WINDOW - 2;
    localparam longint unsigned RECIP = (64'd1 << NW) / DIVISOR;
    localparam logic [NW-1:0] RECIP_V = NW'(RECIP);
    localparam logic [AW-1:0] DIV_V   = AW'(DIVISOR);
    localparam logic [AW-1:0] LAST    = AW'(WINDOW - 1);

    state_t state_reg, state_next;

    logic [AW-1:0]           slot_reg;
    logic [AW-1:0]           cnt_reg;
    logic [WINDOW-1:0]       valid_reg;
    logic                    rd_pend_reg;
    logic                    rd_vld_reg;
    logic                    first_reg;
    logic [TOT_W-1:0]        total_reg;
    logic [SAMPLE_W-1:0]     lo_reg;
    logic [SAMPLE_W-1:0]     hi_reg;
    logic [TOT_W-1:0]        trim_reg;
    logic [2*NW-1:0]         prod_reg;
    logic [MEAN_W-1:0]       q0_reg;
    logic [MEAN_W+AW-1:0]    qd_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;

    logic                    in_fire;
    logic                    out_free;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic [SAMPLE_W-1:0]     rd_val;
    logic [NW-1:0]           n_full;
    logic [NW-1:0]           rem;
    logic [MEAN_W-1:0]       q0_est;
    logic                    sat;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    tmsw_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (in_fire),
        .waddr (slot_reg),
        .wdata (s_axis_tdata[SAMPLE_W-1:0]),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign rd_val = rd_vld_reg ? ram_rdata : '0;
    assign n_full = {trim_reg, MEAN_FRAC'(0)};
    assign rem    = n_full - NW'(qd_reg);
    assign q0_est = prod_reg[NW +: MEAN_W];
    assign sat    = 32'(trim_reg) > 32'(SUM_MAX);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_SCAN;
            S_SCAN:  if (cnt_reg == LAST) state_next = S_DRAIN;
            S_DRAIN: state_next = S_TRIM;
            S_TRIM:  state_next = S_MUL;
            S_MUL:   state_next = S_EST;
            S_EST:   state_next = S_FIX;
            S_FIX:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == S_SCAN);
            rd_vld_reg  <= valid_reg[cnt_reg];

            if (in_fire)
            begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg            <= (slot_reg == LAST) ? '0 : slot_reg + 1'b1;
                cnt_reg             <= '0;
                first_reg           <= 1'b1;
            end
            else if (state_reg == S_SCAN && cnt_reg != LAST)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (rd_pend_reg)
            begin
                first_reg <= 1'b0;
            end

            if (state_reg == S_FIX && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            total_reg <= '0;
        end
        else if (rd_pend_reg)
        begin
            total_reg <= total_reg + TOT_W'(rd_val);
            if (first_reg)
            begin
                lo_reg <= rd_val;
                hi_reg <= rd_val;
            end
            else
            begin
                if (rd_val < lo_reg) lo_reg <= rd_val;
                if (rd_val > hi_reg) hi_reg <= rd_val;
            end
        end

        if (state_reg == S_TRIM)
        begin
            trim_reg <= total_reg - TOT_W'(lo_reg) - TOT_W'(hi_reg);
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= {NW'(0), n_full} * {NW'(0), RECIP_V};
        end
        if (state_reg == S_EST)
        begin
            q0_reg <= q0_est;
            qd_reg <= {AW'(0), q0_est} * {MEAN_W'(0), DIV_V};
        end
        if (state_reg == S_FIX && out_free)
        begin
            out_reg.pad         <= '0;
            out_reg.window_high <= hi_reg;
            out_reg.window_low  <= lo_reg;
            out_reg.mean_q4     <= (rem >= NW'(DIVISOR)) ? q0_reg + 1'b1 : q0_reg;
            out_reg.trimmed_sum <= sat ? SUM_W'(SUM_MAX) : SUM_W'(trim_reg);
        end
    end

endmodule

// ===== hdl/tmsw_checker.sv =====
module tmsw_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [tmsw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tmsw_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tmsw_pkg::*;

    out_item_t res;
    logic      in_hs;

    assign res   = m_axis_tdata;
    assign in_hs = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_hs |=> !s_axis_tready)
        else $error("new sample taken during scan");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.window_low <= res.window_high)
                       && ({res.window_low, 4'b0} <= {2'b0, res.mean_q4})
                       && ({2'b0, res.mean_q4} <= {res.window_high, 4'b0}))
        else $error("mean or extremes out of order");

endmodule

bind trimmed_mean_sample_window_core tmsw_checker u_tmsw_checker (.*);

// ===== sim/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import tmsw_pkg::*;

    localparam int RING_DEPTH  = 40;
    localparam int PROBE_COUNT = 20;
    localparam int PHASE_COUNT = 4;
    localparam int PHASE_ITEMS = 308;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = RING_DEPTH + 20;

    typedef enum int {
        MIX_UNIFORM,
        MIX_FULL,
        MIX_EMPTY,
        MIX_TIES,
        MIX_EDGES,
        MIX_NARROW
    } sample_mix_t;

    typedef struct packed {
        logic [IN_TDATA_W-1:0] word;
        logic                  typed;
        logic [SUM_W-1:0]      sum;
        logic [MEAN_W-1:0]     mean;
        logic [SAMPLE_W-1:0]   low;
        logic [SAMPLE_W-1:0]   high;
    } probe_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [SAMPLE_W-1:0] ring_q [RING_DEPTH];
    int unsigned         ring_slot;
    out_item_t           expected_stats_q [$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int samples_sent    = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int rx_hold_left    = 0;

    // rows with typed values start from a freshly reset ring
    probe_row_t probe_rows [PROBE_COUNT] = '{
        '{16'h0FFF, 1'b1, 18'd0, 16'd0, 12'd0, 12'd4095},
        '{16'hFFFF, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'hF000, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0001, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0800, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0AAA, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0555, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h5A5A, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'hA5A5, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h07FF, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0123, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0123, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0123, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0FFE, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0002, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0FFF, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0000, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h3000, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'hC7FF, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0},
        '{16'h0FFF, 1'b0, 18'd0, 16'd0, 12'd0, 12'd0}
    };

    trimmed_mean_sample_window_core #(
        .WINDOW (RING_DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic out_item_t window_stats(input logic [IN_TDATA_W-1:0] word);
        int unsigned lo;
        int unsigned hi;
        int unsigned total;
        int unsigned trimmed;
        int unsigned mean;
        out_item_t   r;
        if (ring_slot >= RING_DEPTH)
            ring_slot = 0;
        ring_q[ring_slot] = word[SAMPLE_W-1:0];
        ring_slot = (ring_slot + 1 >= RING_DEPTH) ? 0 : ring_slot + 1;
        lo    = ring_q[0];
        hi    = ring_q[0];
        total = 0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            total += ring_q[i];
            if (ring_q[i] < lo)
                lo = ring_q[i];
            if (ring_q[i] > hi)
                hi = ring_q[i];
        end
        trimmed = total - lo - hi;
        mean    = (trimmed << MEAN_FRAC) / (RING_DEPTH - 2);
        r             = '0;
        r.trimmed_sum = (trimmed > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(trimmed);
        r.mean_q4     = MEAN_W'(mean);
        r.window_low  = SAMPLE_W'(lo);
        r.window_high = SAMPLE_W'(hi);
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] draw_sample(input sample_mix_t mix,
                                                          input logic [SAMPLE_W-1:0] tie_a,
                                                          input logic [SAMPLE_W-1:0] tie_b);
        logic [SAMPLE_W-1:0] value;
        logic [3:0]          upper;
        upper = 4'($urandom_range(0, 15));
        case (mix)
            MIX_FULL:   value = SAMPLE_W'(SAMPLE_MAX);
            MIX_EMPTY:  value = '0;
            MIX_TIES:   value = $urandom_range(0, 1) ? tie_a : tie_b;
            MIX_EDGES:  value = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 3))
                                                     : SAMPLE_W'($urandom_range(4092, 4095));
            MIX_NARROW: value = (tie_a & 12'hFF0) + SAMPLE_W'($urandom_range(0, 15));
            default:    value = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
        return {upper, value};
    endfunction

    task automatic push_sample(input logic [IN_TDATA_W-1:0] word, input logic typed,
                               input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = window_stats(word);
        expected_stats_q.push_back(typed ? want : predicted);
        samples_sent++;
    endtask

    task automatic wait_drained();
        while (expected_stats_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void field_mismatch(input string name, input logic [31:0] want,
                                           input logic [31:0] got);
        $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        mismatch_count++;
    endfunction

    task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
        out_item_t got;
        out_item_t want;
        got = out_item_t'(data);
        results_checked++;
        if (expected_stats_q.size() == 0)
        begin
            $display("%0t ns: result with none pending, expected nothing actual %h",
                     $time, data);
            mismatch_count++;
        end
        else
        begin
            want = expected_stats_q.pop_front();
            if (got.trimmed_sum !== want.trimmed_sum)
                field_mismatch("trimmed_sum", 32'(want.trimmed_sum), 32'(got.trimmed_sum));
            if (got.mean_q4 !== want.mean_q4)
                field_mismatch("mean_q4", 32'(want.mean_q4), 32'(got.mean_q4));
            if (got.window_low !== want.window_low)
                field_mismatch("window_low", 32'(want.window_low), 32'(got.window_low));
            if (got.window_high !== want.window_high)
                field_mismatch("window_high", 32'(want.window_high), 32'(got.window_high));
        end
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results pending", expected_stats_q.size());
        $display("trimmed_mean_sample_window_core: mismatch");
        $finish;
    end

    initial
    begin
        int                  send_idle_set [PHASE_COUNT];
        int                  recv_stall_set [PHASE_COUNT];
        int                  sent_in_phase;
        int                  run_len;
        int                  pick;
        sample_mix_t         mix;
        logic [SAMPLE_W-1:0] tie_a;
        logic [SAMPLE_W-1:0] tie_b;
        out_item_t           want;

        send_idle_set  = '{0, 76, 0, 10};
        recv_stall_set = '{0, 0, 76, 10};
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        ring_slot      = 0;
        for (int i = 0; i < RING_DEPTH; i++)
            ring_q[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PROBE_COUNT; r++)
        begin
            want             = '0;
            want.trimmed_sum = probe_rows[r].sum;
            want.mean_q4     = probe_rows[r].mean;
            want.window_low  = probe_rows[r].low;
            want.window_high = probe_rows[r].high;
            push_sample(probe_rows[r].word, probe_rows[r].typed, want);
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            send_idle_pct  = send_idle_set[p];
            recv_stall_pct = recv_stall_set[p];
            // stall the output long enough to back up the input
            if (p == 0)
                rx_hold_left = HOLD_CYCLES;
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS)
            begin
                pick  = $urandom_range(0, 9);
                tie_a = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                tie_b = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                case (pick)
                    5:       mix = MIX_FULL;
                    6:       mix = MIX_EMPTY;
                    7:       mix = MIX_TIES;
                    8:       mix = MIX_EDGES;
                    9:       mix = MIX_NARROW;
                    default: mix = MIX_UNIFORM;
                endcase
                run_len = (mix == MIX_UNIFORM) ? $urandom_range(1, 40) : $urandom_range(10, 50);
                for (int k = 0; k < run_len; k++)
                    push_sample(draw_sample(mix, tie_a, tie_b), 1'b0, '0);
                sent_in_phase += run_len;
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d samples sent over four handshake phases with a long output hold-off;",
                 samples_sent);
        $display("%0d results checked, covering early windows, ties and full-scale windows",
                 results_checked);
        if (mismatch_count == 0 && expected_stats_q.size() == 0)
            $display("trimmed_mean_sample_window_core: match");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatch_count,
                     expected_stats_q.size());
            $display("trimmed_mean_sample_window_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tmsw_pkg.sv
hdl/tmsw_ram.sv
hdl/trimmed_mean_sample_window_core.sv
hdl/tmsw_checker.sv
sim/testbench.sv
